// ===== design/bts_pkg.sv =====
// shared constants, types and helpers of the bundle template slot matcher
`default_nettype none
package bts_pkg;

  localparam int SLOTS       = 3;
  localparam int TEMPLATES   = 32;
  localparam int PROP_BITS   = 8;
  localparam int FIELD_SHIFT = 8;

  localparam int TIDX_W = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
  localparam int PACK_W = 24;

  // item kinds on the request channel
  typedef enum logic [2:0] {
    KIND_CLEAR    = 3'd0,
    KIND_LOAD     = 3'd1,
    KIND_RESERVE  = 3'd2,
    KIND_SET_STOP = 3'd3,
    KIND_CLR_STOP = 3'd4,
    KIND_TRY_SLOT = 3'd5,
    KIND_TRY_STOP = 3'd6
  } kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_REPORT
  } state_t;

  // state update applied by a slot cell
  typedef enum logic [2:0] {
    CELL_NONE,
    CELL_CLEAR,
    CELL_LOAD,
    CELL_RESERVE,
    CELL_SET_STOP,
    CELL_CLR_STOP
  } cell_op_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t               op;
    logic                   try_stop;
    logic [PROP_BITS-1:0]   prop;
    logic [PROP_BITS-1:0]   tprop;
    logic                   tstop;
    logic [TIDX_W-1:0]      waddr;
    logic [TIDX_W-1:0]      raddr;
  } cell_cmd_t;

  // running results handed from cell to cell
  typedef struct packed {
    logic ok;
    logic any_used;
    logic all_used;
    logic any_prop;
  } chain_t;

  // a zero property fits anything, else it must cover the required bits
  function automatic logic fits(input logic [PROP_BITS-1:0] p,
                                input logic [PROP_BITS-1:0] req);
    fits = (p == '0) || ((p & req) == req);
  endfunction

  // property of one slot placed at its field of the packed mask
  function automatic logic [PACK_W-1:0] pack_field(input logic [1:0] slot,
                                                   input logic [PROP_BITS-1:0] p);
    logic [47:0] wide;
    pack_field = '0;
    for (int s = 0; s < SLOTS; s++) begin
      if ((int'(slot) == s) && (FIELD_SHIFT * (SLOTS - 1 - s) < PACK_W)) begin
        wide = 48'(p) << (FIELD_SHIFT * (SLOTS - 1 - s));
        pack_field = wide[PACK_W-1:0];
      end
    end
  endfunction

endpackage
`default_nettype wire

// ===== design/bts_if.sv =====
// request and response channel interfaces of the bundle template slot matcher
`default_nettype none
interface bts_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [1:0] slot;
  logic [7:0] property_req;
  logic [4:0] template_index;
  logic [7:0] template_prop;
  logic       template_stop;

  modport source (output valid, kind, slot, property_req, template_index,
                  template_prop, template_stop, input ready);
  modport sink (input valid, kind, slot, property_req, template_index,
                template_prop, template_stop, output ready);
endinterface

interface bts_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic        bad_slot;
  logic [4:0]  template_code;
  logic        bundle_full;
  logic        bundle_empty;
  logic        has_property;
  logic [23:0] packed_mask;

  modport source (output valid, found, bad_slot, template_code, bundle_full,
                  bundle_empty, has_property, packed_mask, input ready);
  modport sink (input valid, found, bad_slot, template_code, bundle_full,
                bundle_empty, has_property, packed_mask, output ready);
endinterface
`default_nettype wire

// ===== design/bts_cell.sv =====
// one bundle slot: its state, its column of the template table and its match check
`default_nettype none
module bts_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               sel,
  input  wire bts_pkg::cell_cmd_t cmd,
  input  wire bts_pkg::chain_t    chain_in,
  output bts_pkg::chain_t         chain_out
);

  logic                          used;
  logic [bts_pkg::PROP_BITS-1:0] prop;
  logic                          stop;

  // template column: stop bit over required property
  logic [bts_pkg::PROP_BITS:0] mem [bts_pkg::TEMPLATES];
  logic [bts_pkg::PROP_BITS:0] rd_data;

  logic [bts_pkg::PROP_BITS-1:0] t_prop;
  logic                          t_stop;
  logic [bts_pkg::PROP_BITS-1:0] p_chk;
  logic                          checked;
  logic                          sb;
  logic                          ok;

  // slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      prop <= '0;
      stop <= 1'b0;
    end else begin
      case (cmd.op)
        bts_pkg::CELL_CLEAR: begin
          used <= 1'b0;
          prop <= '0;
          stop <= 1'b0;
        end
        bts_pkg::CELL_RESERVE: begin
          if (sel) begin
            used <= 1'b1;
            prop <= cmd.prop;
          end
        end
        bts_pkg::CELL_SET_STOP: begin
          if (sel) stop <= 1'b1;
        end
        bts_pkg::CELL_CLR_STOP: begin
          if (sel) stop <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // template column write and registered read
  always_ff @(posedge clk) begin
    if (cmd.op == bts_pkg::CELL_LOAD && sel) begin
      mem[cmd.waddr] <= {cmd.tstop, cmd.tprop};
    end
    rd_data <= mem[cmd.raddr];
  end

  // match of this slot against the template word just read
  always_comb begin
    t_prop  = rd_data[bts_pkg::PROP_BITS-1:0];
    t_stop  = rd_data[bts_pkg::PROP_BITS];
    p_chk   = sel ? cmd.prop : prop;
    checked = sel || used || stop;
    sb      = sel ? 1'b1 : stop;
    if (cmd.try_stop) begin
      ok = (t_stop == sb) && (!used || bts_pkg::fits(prop, t_prop));
    end else begin
      ok = !checked || (bts_pkg::fits(p_chk, t_prop) && (stop == t_stop));
    end
  end

  // hand the running results on
  always_comb begin
    chain_out.ok       = chain_in.ok && ok;
    chain_out.any_used = chain_in.any_used || used;
    chain_out.all_used = chain_in.all_used && used;
    chain_out.any_prop = chain_in.any_prop || ((prop & cmd.prop) != '0);
  end

endmodule
`default_nettype wire

// ===== design/bundle_template_slot_matcher.sv =====
// top level: sequencer, packed mask and result register over a row of slot cells
//
// Every request word gives exactly one response word. Clear, load, reserve
// and stop updates go from acceptance through the report state to a registered
// response. A try walks the template table one template per cycle, lowest
// number first, through a row of slot cells each holding its own column of the
// table in a small memory with a registered read; all cells check the same
// template in the same cycle and pass their verdict down the row. A try ends
// at the first template that matches or after the last one. One word is worked
// on at a time; a new request is taken once the previous response has been
// taken or is being taken. Template entries never loaded read as undefined.
`default_nettype none
module bundle_template_slot_matcher (
  input  wire logic  clk,
  input  wire logic  rst,
  bts_req_if.sink    req,
  bts_rsp_if.source  rsp
);

  bts_pkg::state_t state, state_next;

  logic                           accept;
  logic                           slot_ok;
  logic                           go_search;
  logic                           found_now;
  logic                           bad_now;
  logic                           last_t;
  logic                           hit;
  logic [1:0]                     slot_mux;
  logic [bts_pkg::SLOTS-1:0]      sel;
  bts_pkg::cell_cmd_t             cmd;
  bts_pkg::chain_t                chain [bts_pkg::SLOTS+1];

  logic [bts_pkg::TIDX_W-1:0]     addr;
  logic [bts_pkg::TIDX_W-1:0]     t_d;
  logic                           rd_valid;
  logic [1:0]                     item_slot;
  logic [bts_pkg::PROP_BITS-1:0]  item_preq;
  logic                           item_try_stop;
  logic                           res_found;
  logic                           res_bad;
  logic [4:0]                     chosen_template;
  logic [bts_pkg::PACK_W-1:0]     prop_mask;

  assign req.ready = (state == bts_pkg::ST_IDLE) && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign slot_ok   = int'(req.slot) < bts_pkg::SLOTS;
  assign slot_mux  = accept ? req.slot : item_slot;
  assign last_t    = (t_d == bts_pkg::TIDX_W'(bts_pkg::TEMPLATES - 1));
  assign hit       = rd_valid && chain[bts_pkg::SLOTS].ok;

  // decode of the incoming word and command fields shared by all cells
  always_comb begin
    cmd.op       = bts_pkg::CELL_NONE;
    cmd.try_stop = item_try_stop;
    cmd.prop     = accept ? bts_pkg::PROP_BITS'(req.property_req) : item_preq;
    cmd.tprop    = bts_pkg::PROP_BITS'(req.template_prop);
    cmd.tstop    = req.template_stop;
    cmd.waddr    = bts_pkg::TIDX_W'(req.template_index);
    cmd.raddr    = addr;
    go_search = 1'b0;
    found_now = 1'b0;
    bad_now   = 1'b0;
    if (accept) begin
      case (bts_pkg::kind_t'(req.kind))
        bts_pkg::KIND_CLEAR: cmd.op = bts_pkg::CELL_CLEAR;
        bts_pkg::KIND_LOAD: begin
          bad_now = !slot_ok;
          if (slot_ok && int'(req.template_index) < bts_pkg::TEMPLATES) begin
            cmd.op = bts_pkg::CELL_LOAD;
          end
        end
        bts_pkg::KIND_RESERVE: begin
          bad_now = !slot_ok;
          if (slot_ok) cmd.op = bts_pkg::CELL_RESERVE;
        end
        bts_pkg::KIND_SET_STOP: begin
          bad_now = !slot_ok;
          if (slot_ok) cmd.op = bts_pkg::CELL_SET_STOP;
        end
        bts_pkg::KIND_CLR_STOP: begin
          bad_now = !slot_ok;
          if (slot_ok) cmd.op = bts_pkg::CELL_CLR_STOP;
        end
        bts_pkg::KIND_TRY_SLOT: begin
          bad_now   = !slot_ok;
          go_search = slot_ok;
        end
        bts_pkg::KIND_TRY_STOP: begin
          bad_now = !slot_ok;
          if (slot_ok && int'(req.slot) == bts_pkg::SLOTS - 1) begin
            found_now = 1'b1;
          end else begin
            go_search = slot_ok;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // slot select of each cell
  always_comb begin
    for (int i = 0; i < bts_pkg::SLOTS; i++) begin
      sel[i] = (int'(slot_mux) == i);
    end
  end

  // row of slot cells
  assign chain[0] = '{ok: 1'b1, any_used: 1'b0, all_used: 1'b1, any_prop: 1'b0};

  for (genvar g = 0; g < bts_pkg::SLOTS; g++) begin : g_cell
    bts_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .sel       (sel[g]),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bts_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bts_pkg::ST_IDLE: begin
        if (accept) state_next = go_search ? bts_pkg::ST_SEARCH : bts_pkg::ST_REPORT;
      end
      bts_pkg::ST_SEARCH: begin
        if (hit || (rd_valid && last_t)) state_next = bts_pkg::ST_REPORT;
      end
      bts_pkg::ST_REPORT: state_next = bts_pkg::ST_IDLE;
      default: state_next = bts_pkg::ST_IDLE;
    endcase
  end

  // item registers and template walk
  always_ff @(posedge clk) begin
    if (rst) begin
      addr            <= '0;
      t_d             <= '0;
      rd_valid        <= 1'b0;
      res_found       <= 1'b0;
      res_bad         <= 1'b0;
      chosen_template <= '0;
      prop_mask       <= '0;
      item_slot       <= '0;
      item_preq       <= '0;
      item_try_stop   <= 1'b0;
    end else begin
      if (accept) begin
        item_slot     <= req.slot;
        item_preq     <= bts_pkg::PROP_BITS'(req.property_req);
        item_try_stop <= (bts_pkg::kind_t'(req.kind) == bts_pkg::KIND_TRY_STOP);
        res_found     <= found_now;
        res_bad       <= bad_now;
        addr          <= '0;
        rd_valid      <= 1'b0;
        if (cmd.op == bts_pkg::CELL_CLEAR) begin
          chosen_template <= '0;
          prop_mask       <= '0;
        end else if (cmd.op == bts_pkg::CELL_RESERVE) begin
          prop_mask <= prop_mask | bts_pkg::pack_field(req.slot, cmd.prop);
        end
      end else if (state == bts_pkg::ST_SEARCH) begin
        rd_valid <= 1'b1;
        t_d      <= addr;
        if (addr != bts_pkg::TIDX_W'(bts_pkg::TEMPLATES - 1)) addr <= addr + 1'b1;
        if (hit) begin
          res_found       <= 1'b1;
          chosen_template <= 5'(t_d);
        end
      end
    end
  end

  // response word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == bts_pkg::ST_REPORT) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bts_pkg::ST_REPORT) begin
      rsp.found         <= res_found;
      rsp.bad_slot      <= res_bad;
      rsp.template_code <= chosen_template;
      rsp.bundle_full   <= chain[bts_pkg::SLOTS].all_used;
      rsp.bundle_empty  <= !chain[bts_pkg::SLOTS].any_used;
      rsp.has_property  <= chain[bts_pkg::SLOTS].any_prop;
      rsp.packed_mask   <= prop_mask;
    end
  end

endmodule
`default_nettype wire

// ===== bench/bundle_template_slot_matcher_checker.sv =====
// checker: predicts each response word of the slot matcher and compares it
module bundle_template_slot_matcher_checker
  import bts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  bts_req_if   req,
  bts_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   checked,
  output int   hits,
  output int   bad_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              found;
    logic              bad_slot;
    logic [4:0]        code;
    logic              full;
    logic              empty;
    logic              has_prop;
    logic [PACK_W-1:0] mask;
  } bundle_status_t;

  // bundle being packed
  logic                 slot_used [SLOTS];
  logic [PROP_BITS-1:0] unit_prop [SLOTS];
  logic                 slot_stop [SLOTS];
  logic [4:0]           chosen;
  logic [PACK_W-1:0]    mask_q;

  // template table, one entry per template and slot
  logic [PROP_BITS-1:0] tmpl_prop [TEMPLATES*SLOTS];
  logic                 tmpl_stop [TEMPLATES*SLOTS];

  bundle_status_t awaited_status [$];
  bundle_status_t want;
  bundle_status_t got;

  function automatic logic prop_covers(input logic [PROP_BITS-1:0] p,
                                       input logic [PROP_BITS-1:0] need);
    return (p == '0) || ((p & need) == need);
  endfunction

  function automatic void empty_bundle();
    for (int s = 0; s < SLOTS; s++) begin
      slot_used[s] = 1'b0;
      unit_prop[s] = '0;
      slot_stop[s] = 1'b0;
    end
    chosen = '0;
    mask_q = '0;
  endfunction

  // apply one request word to the bundle and return its status word
  function automatic bundle_status_t advance_bundle(input logic [2:0] k,
                                                   input logic [1:0] slot,
                                                   input logic [7:0] preq,
                                                   input logic [4:0] tidx,
                                                   input logic [7:0] tprop,
                                                   input logic tstop);
    bundle_status_t r;
    int sl;
    int sh;
    int e;
    logic slot_ok;
    logic hit;
    logic ok;
    logic sb;
    logic [PROP_BITS-1:0] p;
    r = '0;
    sl = int'(slot);
    slot_ok = sl < SLOTS;
    hit = 1'b0;
    case (kind_t'(k))
      KIND_CLEAR: empty_bundle();
      KIND_LOAD: begin
        if (!slot_ok) r.bad_slot = 1'b1;
        else if (int'(tidx) < TEMPLATES) begin
          tmpl_prop[int'(tidx)*SLOTS + sl] = tprop;
          tmpl_stop[int'(tidx)*SLOTS + sl] = tstop;
        end
      end
      KIND_RESERVE: begin
        if (!slot_ok) r.bad_slot = 1'b1;
        else begin
          slot_used[sl] = 1'b1;
          unit_prop[sl] = preq;
          sh = FIELD_SHIFT * (SLOTS - 1 - sl);
          // older bits stay in the mask when a slot is refilled
          if (sh < PACK_W) mask_q = mask_q | (PACK_W'(preq) << sh);
        end
      end
      KIND_SET_STOP, KIND_CLR_STOP: begin
        if (!slot_ok) r.bad_slot = 1'b1;
        else slot_stop[sl] = (kind_t'(k) == KIND_SET_STOP);
      end
      KIND_TRY_SLOT: begin
        if (!slot_ok) r.bad_slot = 1'b1;
        else begin
          // tried slot, filled slots and stopped slots must all fit
          for (int t = 0; t < TEMPLATES; t++) begin
            if (!hit) begin
              ok = 1'b1;
              for (int s = 0; s < SLOTS; s++) begin
                if (s == sl || slot_used[s] || slot_stop[s]) begin
                  p = (s == sl) ? preq : unit_prop[s];
                  e = t * SLOTS + s;
                  if (!prop_covers(p, tmpl_prop[e]) || slot_stop[s] != tmpl_stop[e])
                    ok = 1'b0;
                end
              end
              if (ok) begin
                hit = 1'b1;
                chosen = t[4:0];
              end
            end
          end
          r.found = hit;
        end
      end
      KIND_TRY_STOP: begin
        if (!slot_ok) r.bad_slot = 1'b1;
        else if (sl == SLOTS - 1) r.found = 1'b1;
        else begin
          // every stop bit must agree, properties only on filled slots
          for (int t = 0; t < TEMPLATES; t++) begin
            if (!hit) begin
              ok = 1'b1;
              for (int s = 0; s < SLOTS; s++) begin
                e = t * SLOTS + s;
                sb = (s == sl) ? 1'b1 : slot_stop[s];
                if (tmpl_stop[e] != sb) ok = 1'b0;
                else if (slot_used[s] && !prop_covers(unit_prop[s], tmpl_prop[e]))
                  ok = 1'b0;
              end
              if (ok) begin
                hit = 1'b1;
                chosen = t[4:0];
              end
            end
          end
          r.found = hit;
        end
      end
      default: ;
    endcase
    // status after the word
    r.full = 1'b1;
    r.empty = 1'b1;
    for (int s = 0; s < SLOTS; s++) begin
      if (slot_used[s]) r.empty = 1'b0;
      else r.full = 1'b0;
      if ((unit_prop[s] & preq) != '0) r.has_prop = 1'b1;
    end
    r.code = chosen;
    r.mask = mask_q;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] expv,
                                 input logic [31:0] gotv);
    $display("mismatch at response %0d: %s expected %0h got %0h",
             checked, field, expv, gotv);
    errors++;
  endtask

  // watch both channels at every edge
  always @(posedge clk) begin
    if (rst) begin
      empty_bundle();
      awaited_status.delete();
      errors = 0;
      checked = 0;
      hits = 0;
      bad_words = 0;
      pending <= 0;
    end else begin
      if (req.valid && req.ready) begin
        want = advance_bundle(req.kind, req.slot, req.property_req, req.template_index,
                              req.template_prop, req.template_stop);
        if (want.found) hits++;
        if (want.bad_slot) bad_words++;
        awaited_status.push_back(want);
      end
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.found, rsp.bad_slot, rsp.template_code, rsp.bundle_full,
                rsp.bundle_empty, rsp.has_property, rsp.packed_mask};
        if (awaited_status.size() == 0) begin
          report_mismatch("word with nothing awaited", 0, 1);
        end else begin
          want = awaited_status.pop_front();
          if (got.found !== want.found) report_mismatch("found", want.found, got.found);
          if (got.bad_slot !== want.bad_slot)
            report_mismatch("bad_slot", want.bad_slot, got.bad_slot);
          if (got.code !== want.code)
            report_mismatch("template_code", want.code, got.code);
          if (got.full !== want.full) report_mismatch("bundle_full", want.full, got.full);
          if (got.empty !== want.empty)
            report_mismatch("bundle_empty", want.empty, got.empty);
          if (got.has_prop !== want.has_prop)
            report_mismatch("has_property", want.has_prop, got.has_prop);
          if (got.mask !== want.mask)
            report_mismatch("packed_mask", want.mask, got.mask);
          checked++;
        end
      end
      pending <= awaited_status.size();
    end
  end

endmodule

// ===== bench/bundle_template_slot_matcher_tb.sv =====
// testbench top: clock, reset, request stimulus, response stalls and verdict
module bundle_template_slot_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bts_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 280;

  logic clk;
  logic rst;
  bts_req_if req();
  bts_rsp_if rsp();

  int errors;
  int pending;
  int checked;
  int hits;
  int bad_words;
  int sent_by_kind [8];
  int cycle_count;
  int stall_left;
  int n_random;
  bit quiet;
  bit paused_mid;

  bundle_template_slot_matcher dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  bundle_template_slot_matcher_checker match_chk (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .hits      (hits),
    .bad_words (bad_words)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // properties lean toward zero and single bits so templates fit often
  function automatic logic [7:0] pick_prop();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h00;
    if (r < 7) return 8'h01 << $urandom_range(0, 7);
    if (r == 7) return 8'hFF;
    return 8'($urandom);
  endfunction

  // response side stalls
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      rsp.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp.ready <= 1'b1;
      if (!quiet) stall_left = pick_gap();
    end
  end

  // drive one request word and hold it until taken
  task automatic send_word(input logic [2:0] k, input logic [1:0] sl,
                           input logic [7:0] p, input logic [4:0] ti,
                           input logic [7:0] tp, input logic ts);
    int gap;
    req.valid <= 1'b1;
    req.kind <= k;
    req.slot <= sl;
    req.property_req <= p;
    req.template_index <= ti;
    req.template_prop <= tp;
    req.template_stop <= ts;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent_by_kind[k]++;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every awaited response has come
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    logic [1:0] sl;
    logic [7:0] p;
    req.valid <= 1'b0;
    req.kind <= KIND_CLEAR;
    req.slot <= '0;
    req.property_req <= '0;
    req.template_index <= '0;
    req.template_prop <= '0;
    req.template_stop <= 1'b0;
    rst <= 1'b1;
    quiet = 1'b0;
    paused_mid = 1'b0;
    n_random = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // fill every template entry before any try can read it
    for (int t = 0; t < TEMPLATES; t++) begin
      for (int s = 0; s < SLOTS; s++) begin
        send_word(KIND_LOAD, 2'(s), 8'($urandom), 5'(t), pick_prop(),
                  $urandom_range(0, 3) == 0);
      end
    end

    // directed words: range errors, refill, last-slot stop, unknown kind
    send_word(KIND_TRY_SLOT, 2'd3, 8'h00, 5'($urandom), 8'($urandom), 1'b0);
    send_word(KIND_TRY_STOP, 2'd3, 8'hFF, 5'($urandom), 8'($urandom), 1'b1);
    send_word(KIND_RESERVE, 2'd3, 8'hFF, 5'($urandom), 8'($urandom), 1'b0);
    send_word(KIND_SET_STOP, 2'd3, 8'h00, 5'($urandom), 8'($urandom), 1'b1);
    send_word(KIND_CLR_STOP, 2'd3, 8'h00, 5'($urandom), 8'($urandom), 1'b0);
    send_word(KIND_LOAD, 2'd3, 8'h00, 5'd5, 8'hFF, 1'b1);
    send_word(KIND_TRY_SLOT, 2'd0, 8'h00, 5'd0, 8'h00, 1'b0);
    send_word(KIND_RESERVE, 2'd0, 8'hFF, 5'd31, 8'h00, 1'b0);
    send_word(KIND_RESERVE, 2'd1, 8'h00, 5'd0, 8'hFF, 1'b1);
    send_word(KIND_RESERVE, 2'd2, 8'h01, 5'd0, 8'h00, 1'b0);
    send_word(KIND_TRY_STOP, 2'd2, 8'h01, 5'd0, 8'h00, 1'b0);
    send_word(KIND_TRY_STOP, 2'd0, 8'h80, 5'd0, 8'h00, 1'b0);
    send_word(KIND_SET_STOP, 2'd1, 8'h00, 5'd0, 8'h00, 1'b0);
    send_word(KIND_TRY_SLOT, 2'd1, 8'h80, 5'd0, 8'h00, 1'b0);
    send_word(KIND_CLR_STOP, 2'd1, 8'h00, 5'd0, 8'h00, 1'b0);
    send_word(KIND_RESERVE, 2'd0, 8'h10, 5'd0, 8'h00, 1'b0);
    send_word(3'd7, 2'd0, 8'hFF, 5'd31, 8'hFF, 1'b1);
    send_word(KIND_LOAD, 2'd2, 8'h00, 5'd31, 8'hFF, 1'b1);
    send_word(KIND_LOAD, 2'd0, 8'h00, 5'd0, 8'h00, 1'b0);
    send_word(KIND_CLEAR, 2'd0, 8'hFF, 5'd0, 8'h00, 1'b0);
    send_word(KIND_TRY_SLOT, 2'd2, 8'hFF, 5'd0, 8'h00, 1'b0);
    send_word(KIND_TRY_STOP, 2'd1, 8'h00, 5'd0, 8'h00, 1'b0);
    send_word(KIND_RESERVE, 2'd2, 8'h80, 5'd0, 8'h00, 1'b0);
    wait_drained();

    // random part: mostly packing sequences, some noise
    while (n_random < RANDOM_WORDS) begin
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), pick_prop(),
                    5'($urandom), pick_prop(), 1'($urandom));
          n_random++;
        end
      end else begin
        send_word(KIND_CLEAR, 2'($urandom), pick_prop(), 5'($urandom), 8'($urandom),
                  1'($urandom));
        n_random++;
        repeat ($urandom_range(1, 4)) begin
          // now and then an out-of-range slot breaks the sequence
          sl = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, SLOTS - 1));
          p = pick_prop();
          if ($urandom_range(0, 4) == 0) begin
            send_word(KIND_SET_STOP, sl, p, 5'($urandom), 8'($urandom), 1'($urandom));
            n_random++;
          end
          send_word(KIND_TRY_SLOT, sl, p, 5'($urandom), 8'($urandom), 1'($urandom));
          n_random++;
          if ($urandom_range(0, 4) != 0) begin
            send_word(KIND_RESERVE, sl, p, 5'($urandom), 8'($urandom), 1'($urandom));
            n_random++;
          end
          if ($urandom_range(0, 3) == 0) begin
            send_word(KIND_TRY_STOP, 2'($urandom_range(0, 3)), pick_prop(), 5'($urandom),
                      8'($urandom), 1'($urandom));
            n_random++;
          end
          if ($urandom_range(0, 5) == 0) begin
            send_word(KIND_CLR_STOP, 2'($urandom_range(0, 3)), pick_prop(), 5'($urandom),
                      8'($urandom), 1'($urandom));
            n_random++;
          end
          if ($urandom_range(0, 7) == 0) begin
            send_word(KIND_LOAD, 2'($urandom_range(0, 3)), pick_prop(), 5'($urandom),
                      pick_prop(), $urandom_range(0, 3) == 0);
            n_random++;
          end
        end
      end
      if (!paused_mid && n_random >= RANDOM_WORDS / 2) begin
        paused_mid = 1'b1;
        wait_drained();
      end
    end

    // drain, then allow for a full search before the verdict
    quiet = 1'b0;
    wait_drained();
    repeat (TEMPLATES + 8) @(posedge clk);

    $display("covered %0d clears, %0d loads, %0d reserves, %0d stop updates, %0d tries, %0d unknown",
             sent_by_kind[KIND_CLEAR], sent_by_kind[KIND_LOAD], sent_by_kind[KIND_RESERVE],
             sent_by_kind[KIND_SET_STOP] + sent_by_kind[KIND_CLR_STOP],
             sent_by_kind[KIND_TRY_SLOT] + sent_by_kind[KIND_TRY_STOP], sent_by_kind[7]);
    $display("%0d responses checked, %0d tries fitted a template, %0d out-of-range slots",
             checked, hits, bad_words);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== bundle_template_slot_matcher.f =====
design/bts_pkg.sv
design/bts_if.sv
design/bts_cell.sv
design/bundle_template_slot_matcher.sv
bench/bundle_template_slot_matcher_checker.sv
bench/bundle_template_slot_matcher_tb.sv
